[src/c_number_literal_lexer_defines.svh]
// Assertion helpers for the lexer
`ifndef C_NUMBER_LITERAL_LEXER_DEFINES_SVH
`define C_NUMBER_LITERAL_LEXER_DEFINES_SVH

// same-cycle implication
`define CLNL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLNL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/clnl_pkg.sv]
package clnl_pkg;

    localparam int MAX_LEN = 255;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_PREFIX = 3'd1;
    localparam logic [2:0] ST_PERIOD = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_DIGIT  = 3'd4;
    localparam logic [2:0] ST_SUFFIX = 3'd5;

    localparam logic [1:0] BK_DEC = 2'd0;
    localparam logic [1:0] BK_HEX = 2'd1;
    localparam logic [1:0] BK_BIN = 2'd2;
    localparam logic [1:0] BK_OCT = 2'd3;

    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_INT       = 8'b0000_0010,
        PH_FRAC      = 8'b0000_0100,
        PH_EXP_START = 8'b0000_1000,
        PH_EXP       = 8'b0001_0000,
        PH_BASED     = 8'b0010_0000,
        PH_SUF_U     = 8'b0100_0000,
        PH_SUF_END   = 8'b1000_0000
    } t_phase;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] base;
        logic       is_float;
        logic       is_unsigned;
        logic       is_long;
        logic [7:0] int_digits;
        logic [7:0] frac_digits;
        logic       has_exponent;
        logic [7:0] exp_digits;
        logic [7:0] length;
        logic [7:0] error_offset;
    } t_out_item;

    typedef struct packed {
        logic      emit;
        t_out_item item;
    } t_step_res;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (32'(v) < 32'(MAX_LEN)) ? t_cnt'(v + 1'b1) : t_cnt'(MAX_LEN);
    endfunction

    function automatic logic [7:0] clip8(input t_cnt v);
        return (32'(v) > 32'd255) ? 8'hFF : 8'(v);
    endfunction

endpackage

[src/clnl_in_reg.sv]
module clnl_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  clnl_pkg::t_in_item  i_in_item,
    input  logic                i_pop,
    output logic                o_in_ready,
    output logic                o_valid,
    output clnl_pkg::t_in_item  o_item
);

    logic               r_valid;
    logic               n_valid;
    clnl_pkg::t_in_item r_item;
    logic               accept;

    assign o_in_ready = !r_valid || i_pop;
    assign accept     = i_in_valid && o_in_ready;
    assign n_valid    = (r_valid && !i_pop) || accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[src/clnl_step.sv]
`include "c_number_literal_lexer_defines.svh"

module clnl_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  clnl_pkg::t_in_item  i_item,
    output clnl_pkg::t_step_res o_res
);

    clnl_pkg::t_phase r_phase, n_phase;
    clnl_pkg::t_cnt   r_int, n_int;
    clnl_pkg::t_cnt   r_frac, n_frac;
    clnl_pkg::t_cnt   r_exp, n_exp;
    clnl_pkg::t_cnt   r_char, n_char;
    clnl_pkg::t_cnt   r_err_pos, n_err_pos;
    logic             r_lead0, n_lead0;
    logic [1:0]       r_base, n_base;
    logic             r_float, n_float;
    logic             r_long, n_long;
    logic             r_uns, n_uns;
    logic             r_err_seen, n_err_seen;
    logic             r_exp_seen, n_exp_seen;

    logic [7:0]       c;
    logic [7:0]       lc;
    logic             is_dig;
    logic             is_let;
    logic             bad_bin;
    logic             bad_oct;
    logic             num_end;
    logic             emit;
    logic [2:0]       st;
    clnl_pkg::t_cnt   off;

    assign c       = i_item.ch;
    assign lc      = i_item.ch | clnl_pkg::CASE_BIT;
    assign is_dig  = (c >= clnl_pkg::CH_0) && (c <= clnl_pkg::CH_9);
    assign is_let  = (lc >= clnl_pkg::CH_A) && (lc <= clnl_pkg::CH_Z);
    assign bad_bin = !((c == clnl_pkg::CH_0) || (c == clnl_pkg::CH_1));
    assign bad_oct = !((c >= clnl_pkg::CH_0) && (c <= clnl_pkg::CH_7));

    always_comb begin
        n_phase    = r_phase;
        n_int      = r_int;
        n_frac     = r_frac;
        n_exp      = r_exp;
        n_char     = r_char;
        n_err_pos  = r_err_pos;
        n_lead0    = r_lead0;
        n_base     = r_base;
        n_float    = r_float;
        n_long     = r_long;
        n_uns      = r_uns;
        n_err_seen = r_err_seen;
        n_exp_seen = r_exp_seen;
        num_end    = 1'b0;
        emit       = 1'b0;
        st         = clnl_pkg::ST_OK;
        off        = '0;

        if (i_item.start_req) begin
            n_int      = '0;
            n_frac     = '0;
            n_exp      = '0;
            n_char     = '0;
            n_err_pos  = '0;
            n_lead0    = 1'b0;
            n_base     = clnl_pkg::BK_DEC;
            n_float    = 1'b0;
            n_long     = 1'b0;
            n_uns      = 1'b0;
            n_err_seen = 1'b0;
            n_exp_seen = 1'b0;
            if (is_dig) begin
                n_phase = clnl_pkg::PH_INT;
                n_int   = clnl_pkg::t_cnt'(1);
                n_lead0 = (c == clnl_pkg::CH_0);
                n_char  = clnl_pkg::t_cnt'(1);
            end else if (c == clnl_pkg::CH_DOT) begin
                n_phase = clnl_pkg::PH_FRAC;
                n_char  = clnl_pkg::t_cnt'(1);
            end else begin
                emit = 1'b1;
                st   = clnl_pkg::ST_PREFIX;
            end
        end else begin
            case (r_phase)
                clnl_pkg::PH_INT: begin
                    if (is_dig) begin
                        if ((r_int == clnl_pkg::t_cnt'(1)) && r_lead0) begin
                            n_base  = clnl_pkg::BK_OCT;
                            n_phase = clnl_pkg::PH_BASED;
                            if (bad_oct && !r_err_seen) begin
                                n_err_seen = 1'b1;
                                n_err_pos  = r_char;
                            end
                            n_frac = clnl_pkg::sat_inc(r_frac);
                        end else begin
                            n_int = clnl_pkg::sat_inc(r_int);
                        end
                    end else if (lc == clnl_pkg::CH_E) begin
                        n_exp_seen = 1'b1;
                        n_phase    = clnl_pkg::PH_EXP_START;
                    end else if (lc == clnl_pkg::CH_X) begin
                        n_base  = clnl_pkg::BK_HEX;
                        n_phase = clnl_pkg::PH_BASED;
                    end else if (lc == clnl_pkg::CH_B) begin
                        n_base  = clnl_pkg::BK_BIN;
                        n_phase = clnl_pkg::PH_BASED;
                    end else if (c == clnl_pkg::CH_DOT) begin
                        n_phase = clnl_pkg::PH_FRAC;
                    end else begin
                        num_end = 1'b1;
                    end
                end
                clnl_pkg::PH_FRAC: begin
                    if (is_dig) begin
                        n_frac = clnl_pkg::sat_inc(r_frac);
                    end else if (lc == clnl_pkg::CH_E) begin
                        n_exp_seen = 1'b1;
                        n_phase    = clnl_pkg::PH_EXP_START;
                    end else if (c == clnl_pkg::CH_DOT) begin
                        emit = 1'b1;
                        st   = clnl_pkg::ST_PERIOD;
                        off  = r_char;
                    end else begin
                        num_end = 1'b1;
                    end
                end
                clnl_pkg::PH_EXP_START, clnl_pkg::PH_EXP: begin
                    if (is_dig) begin
                        n_exp   = clnl_pkg::sat_inc(r_exp);
                        n_phase = clnl_pkg::PH_EXP;
                    end else if ((r_phase == clnl_pkg::PH_EXP_START) &&
                                 ((c == clnl_pkg::CH_PLUS) || (c == clnl_pkg::CH_MINUS))) begin
                        n_phase = clnl_pkg::PH_EXP;
                    end else begin
                        num_end = 1'b1;
                    end
                end
                clnl_pkg::PH_BASED: begin
                    if (is_dig || is_let) begin
                        if (!r_err_seen &&
                            (((r_base == clnl_pkg::BK_BIN) && bad_bin) ||
                             ((r_base == clnl_pkg::BK_OCT) && bad_oct))) begin
                            n_err_seen = 1'b1;
                            n_err_pos  = r_char;
                        end
                        n_frac = clnl_pkg::sat_inc(r_frac);
                    end else begin
                        emit = 1'b1;
                        if ((r_int != clnl_pkg::t_cnt'(1)) || ((r_frac != '0) && !r_lead0)) begin
                            st  = clnl_pkg::ST_PREFIX;
                            off = r_int;
                        end else if (r_frac == '0) begin
                            st = clnl_pkg::ST_EMPTY;
                        end else if (r_err_seen) begin
                            st  = clnl_pkg::ST_DIGIT;
                            off = r_err_pos;
                        end
                    end
                end
                clnl_pkg::PH_SUF_U: begin
                    if (lc == clnl_pkg::CH_L) begin
                        n_long  = 1'b1;
                        n_phase = clnl_pkg::PH_SUF_END;
                    end else begin
                        emit = 1'b1;
                        if (is_let) begin
                            st  = clnl_pkg::ST_SUFFIX;
                            off = r_char;
                        end
                    end
                end
                clnl_pkg::PH_SUF_END: begin
                    emit = 1'b1;
                    if (is_let) begin
                        st  = clnl_pkg::ST_SUFFIX;
                        off = r_char;
                    end
                end
                default: begin
                end
            endcase

            if (num_end) begin
                if (!is_let) begin
                    emit = 1'b1;
                end else if (lc == clnl_pkg::CH_F) begin
                    n_float = 1'b1;
                    n_phase = clnl_pkg::PH_SUF_END;
                end else if (lc == clnl_pkg::CH_L) begin
                    n_long  = 1'b1;
                    n_phase = clnl_pkg::PH_SUF_END;
                end else if (lc == clnl_pkg::CH_U) begin
                    n_uns   = 1'b1;
                    n_phase = clnl_pkg::PH_SUF_U;
                end else begin
                    emit = 1'b1;
                    st   = clnl_pkg::ST_SUFFIX;
                    off  = r_char;
                end
            end

            if (!emit && (r_phase != clnl_pkg::PH_IDLE)) begin
                n_char = clnl_pkg::sat_inc(r_char);
            end
        end

        if (emit) begin
            n_phase = clnl_pkg::PH_IDLE;
        end
    end

    always_comb begin
        o_res.emit              = emit;
        o_res.item.status       = st;
        o_res.item.base         = n_base;
        o_res.item.is_float     = n_float;
        o_res.item.is_unsigned  = n_uns;
        o_res.item.is_long      = n_long;
        o_res.item.int_digits   = clnl_pkg::clip8(n_int);
        o_res.item.frac_digits  = clnl_pkg::clip8(n_frac);
        o_res.item.has_exponent = n_exp_seen;
        o_res.item.exp_digits   = clnl_pkg::clip8(n_exp);
        o_res.item.length       = clnl_pkg::clip8(n_char);
        o_res.item.error_offset = (st == clnl_pkg::ST_OK) ? 8'd0 : clnl_pkg::clip8(off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= clnl_pkg::PH_IDLE;
            r_int      <= '0;
            r_frac     <= '0;
            r_exp      <= '0;
            r_char     <= '0;
            r_err_pos  <= '0;
            r_lead0    <= 1'b0;
            r_base     <= clnl_pkg::BK_DEC;
            r_float    <= 1'b0;
            r_long     <= 1'b0;
            r_uns      <= 1'b0;
            r_err_seen <= 1'b0;
            r_exp_seen <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_int      <= n_int;
            r_frac     <= n_frac;
            r_exp      <= n_exp;
            r_char     <= n_char;
            r_err_pos  <= n_err_pos;
            r_lead0    <= n_lead0;
            r_base     <= n_base;
            r_float    <= n_float;
            r_long     <= n_long;
            r_uns      <= n_uns;
            r_err_seen <= n_err_seen;
            r_exp_seen <= n_exp_seen;
        end
    end

    `CLNL_ASSERT_NEXT(a_emit_closes, i_clk, i_rst_n, i_fire && emit,
        r_phase == clnl_pkg::PH_IDLE, "phase not idle after a result")
    `CLNL_ASSERT_NEXT(a_hold_when_idle, i_clk, i_rst_n, !i_fire,
        $stable(r_phase) && $stable(r_char), "state moved without an item")
    `CLNL_ASSERT_NOW(a_base_err_only_based, i_clk, i_rst_n,
        r_err_seen, r_base == clnl_pkg::BK_BIN || r_base == clnl_pkg::BK_OCT,
        "digit error recorded outside binary or octal")

endmodule

[src/clnl_out_reg.sv]
module clnl_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  clnl_pkg::t_step_res i_res,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output clnl_pkg::t_out_item o_out_item,
    output logic                o_free
);

    logic                r_valid;
    logic                n_valid;
    clnl_pkg::t_out_item r_item;
    logic                load;

    assign o_free  = !r_valid || i_out_ready;
    assign load    = i_fire && i_res.emit;
    assign n_valid = (r_valid && !i_out_ready) || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_res.item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

[src/c_number_literal_lexer.sv]
// C numeric literal lexer.
// Input channel: i_in_valid / o_in_ready carry one character item (ch, start_req).
// start_req marks the first character of a literal; ch 0 is a plain terminator.
// Output channel: o_out_valid / i_out_ready carry one result item, produced
// when a character cannot continue the literal (or at once on a bad start).
// The terminating character itself is consumed and not reused.
// Flow: an accepted item sits in the input register; once the result
// register is free, the step logic updates the lexer state and loads the
// result register, which drives o_out_valid.
// Throughput: one character per cycle while the result register is free; the
// combinational state transition between the two registers sets this figure.
// Stall: while a result waits, the next character is still taken into the
// input register; it is processed once the result register frees up, and
// o_in_ready drops only when both stages are full.
// Reset (i_rst_n low, synchronous): both registers empty, no literal open.
module c_number_literal_lexer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  clnl_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output clnl_pkg::t_out_item o_out_item
);

    logic                in_valid;
    clnl_pkg::t_in_item  in_item;
    logic                out_free;
    logic                fire;
    clnl_pkg::t_step_res res;

    assign fire = in_valid && out_free;

    clnl_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_pop      (fire),
        .o_in_ready (o_in_ready),
        .o_valid    (in_valid),
        .o_item     (in_item)
    );

    clnl_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (in_item),
        .o_res   (res)
    );

    clnl_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_free      (out_free)
    );

endmodule
